// ----- rtl/orsat_pkg.sv -----
// orsat_pkg: shared types and constants for the oriented rectangle overlap test
// cordic arctangent table, trig format constants and the cordic cell payload type
// no dependencies
`timescale 1ns / 1ps

package orsat_pkg;

  localparam int unsigned PHASE_BITS   = 24;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CW           = 34;  // cordic datapath width, 30 fractional bits
  localparam int unsigned TRIG_W       = 16;  // Q1.14 plus sign
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    logic signed [PHASE_BITS-1:0] z;
    logic [1:0] quad;
  } cordic_t;

  function automatic logic signed [PHASE_BITS-1:0] atan_phase(input logic [3:0] i);
    logic signed [PHASE_BITS-1:0] r;
    unique case (i)
      4'd0:  r = 24'sd2097152;
      4'd1:  r = 24'sd1238021;
      4'd2:  r = 24'sd654136;
      4'd3:  r = 24'sd332050;
      4'd4:  r = 24'sd166669;
      4'd5:  r = 24'sd83416;
      4'd6:  r = 24'sd41718;
      4'd7:  r = 24'sd20860;
      4'd8:  r = 24'sd10430;
      4'd9:  r = 24'sd5215;
      4'd10: r = 24'sd2608;
      4'd11: r = 24'sd1304;
      4'd12: r = 24'sd652;
      4'd13: r = 24'sd326;
      4'd14: r = 24'sd163;
      default: r = 24'sd81;
    endcase
    return r;
  endfunction

  // round half up to Q1.14 and clamp
  function automatic trig_t round_trig(input cw_t v);
    cw_t r;
    cw_t t;
    r = v + cw_t'(34'sd32768);
    t = r >>> 16;
    if (t > cw_t'(TRIG_ONE)) return TRIG_ONE;
    if (t < -cw_t'(TRIG_ONE)) return -TRIG_ONE;
    return trig_t'(t);
  endfunction

endpackage

// ----- rtl/orsat_cordic_cell.sv -----
// orsat_cordic_cell: one rotation step of the cordic chain, registered
// depends on orsat_pkg
`timescale 1ns / 1ps

module orsat_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  orsat_pkg::cordic_t in_i,
  output orsat_pkg::cordic_t out_o
);
  import orsat_pkg::*;

  cordic_t d;
  cw_t     xs;
  cw_t     ys;
  logic signed [PHASE_BITS-1:0] at;

  always_comb begin
    xs = in_i.x >>> STEP;
    ys = in_i.y >>> STEP;
    at = atan_phase(4'(STEP));
    d  = in_i;
    if (!in_i.z[PHASE_BITS-1]) begin
      d.x = in_i.x - ys;
      d.y = in_i.y + xs;
      d.z = in_i.z - at;
    end else begin
      d.x = in_i.x + ys;
      d.y = in_i.y - xs;
      d.z = in_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_o <= d;
  end

endmodule

// ----- rtl/orsat_sincos.sv -----
// orsat_sincos: pipelined cordic sine and cosine, a chain of rotation cells
// depends on orsat_pkg, orsat_cordic_cell; every cell and the quadrant correction are registered
`timescale 1ns / 1ps

module orsat_sincos #(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output orsat_pkg::trig_t       cos_o,
  output orsat_pkg::trig_t       sin_o
);
  import orsat_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  cordic_t chain [CORDIC_STEPS+1];
  trig_t rc;
  trig_t rs;

  assign phase = PHASE_BITS'(angle_i) << (PHASE_BITS - ANGLE_WIDTH);

  assign chain[0].x    = CORDIC_X0;
  assign chain[0].y    = '0;
  assign chain[0].z    = {2'b00, phase[PHASE_BITS-3:0]};
  assign chain[0].quad = phase[PHASE_BITS-1 -: 2];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    orsat_cordic_cell #(.STEP(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .in_i  (chain[g]),
      .out_o (chain[g+1])
    );
  end

  assign rc = round_trig(chain[CORDIC_STEPS].x);
  assign rs = round_trig(chain[CORDIC_STEPS].y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (chain[CORDIC_STEPS].quad)
        2'd0: begin cos_o <= rc;  sin_o <= rs;  end
        2'd1: begin cos_o <= -rs; sin_o <= rc;  end
        2'd2: begin cos_o <= -rc; sin_o <= -rs; end
        default: begin cos_o <= rs; sin_o <= -rc; end
      endcase
    end
  end

endmodule

// ----- rtl/oriented_rect_overlap_test_top.sv -----
// oriented_rect_overlap_test_top: separating axis test for two rotated rectangles
// input to result: 16 cordic cells per angle, quadrant register, stages s1 to s5;
// one pair per cycle unless the output stalls; all stages advance together
// a stalled output freezes the whole pipe; a skid-free design, input stall follows
// output stall; rst_ni clears valid bits only, payload registers are not reset
// depends on orsat_pkg, orsat_sincos
`timescale 1ns / 1ps

module oriented_rect_overlap_test_top #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] a_left_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_i,
  input  logic        [COORD_WIDTH-1:0] a_width_i,
  input  logic        [COORD_WIDTH-1:0] a_height_i,
  input  logic        [ANGLE_WIDTH-1:0] a_angle_i,
  input  logic signed [COORD_WIDTH-1:0] b_left_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_i,
  input  logic        [COORD_WIDTH-1:0] b_width_i,
  input  logic        [COORD_WIDTH-1:0] b_height_i,
  input  logic        [ANGLE_WIDTH-1:0] b_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          colliding_o
);
  import orsat_pkg::*;

  localparam int unsigned TRIG_LAT = CORDIC_STEPS + 1;
  localparam int unsigned DEPTH    = TRIG_LAT + 5;
  localparam int unsigned CX_W = COORD_WIDTH + 2;     // doubled center
  localparam int unsigned D_W  = COORD_WIDTH + 3;     // center difference
  localparam int unsigned P_W  = D_W + TRIG_W + 1;    // dot product of d with axis
  localparam int unsigned SZ_W = COORD_WIDTH + 1;     // signed size
  localparam int unsigned Q_W  = 2*TRIG_W + 2;        // axis dot direction
  localparam int unsigned E_W  = COORD_WIDTH + Q_W + 2;
  localparam int unsigned DS_W = P_W + 14 + 1;
  localparam int unsigned CMP_W = (DS_W > E_W) ? DS_W : E_W;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] aw;
    logic [COORD_WIDTH-1:0] ah;
    logic [COORD_WIDTH-1:0] bw;
    logic [COORD_WIDTH-1:0] bh;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
  } geo_t;

  logic adv;
  logic [DEPTH-1:0] vld_q;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // stage 0: centers and difference, carried alongside the cordic chain
  geo_t geo_d;
  geo_t geo_q [TRIG_LAT];
  logic signed [CX_W-1:0] acx, acy, bcx, bcy;

  always_comb begin
    acx = (CX_W'(a_left_i) <<< 1) + CX_W'({1'b0, a_width_i});
    acy = (CX_W'(a_top_i)  <<< 1) + CX_W'({1'b0, a_height_i});
    bcx = (CX_W'(b_left_i) <<< 1) + CX_W'({1'b0, b_width_i});
    bcy = (CX_W'(b_top_i)  <<< 1) + CX_W'({1'b0, b_height_i});
    geo_d.aw = a_width_i;
    geo_d.ah = a_height_i;
    geo_d.bw = b_width_i;
    geo_d.bh = b_height_i;
    geo_d.dx = D_W'(bcx) - D_W'(acx);
    geo_d.dy = D_W'(bcy) - D_W'(acy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo_q[0] <= geo_d;
      for (int i = 1; i < TRIG_LAT; i++) geo_q[i] <= geo_q[i-1];
    end
  end

  trig_t ca, sa, cb, sb;

  orsat_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_a (
    .clk_i (clk_i), .en_i (adv), .angle_i (a_angle_i), .cos_o (ca), .sin_o (sa)
  );
  orsat_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_b (
    .clk_i (clk_i), .en_i (adv), .angle_i (b_angle_i), .cos_o (cb), .sin_o (sb)
  );

  // stage s1: axes
  geo_t  g1_q;
  trig_t ca1_q, sa1_q, cb1_q, sb1_q;
  trig_t ux1_q [4];
  trig_t uy1_q [4];
  geo_t  gl;
  assign gl = geo_q[TRIG_LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_q  <= gl;
      ca1_q <= ca; sa1_q <= sa; cb1_q <= cb; sb1_q <= sb;
      ux1_q[0] <= (gl.aw != '0) ? ca  : '0;
      uy1_q[0] <= (gl.aw != '0) ? sa  : '0;
      ux1_q[1] <= (gl.ah != '0) ? -sa : '0;
      uy1_q[1] <= (gl.ah != '0) ? ca  : '0;
      ux1_q[2] <= (gl.bw != '0) ? cb  : '0;
      uy1_q[2] <= (gl.bw != '0) ? sb  : '0;
      ux1_q[3] <= (gl.bh != '0) ? -sb : '0;
      uy1_q[3] <= (gl.bh != '0) ? cb  : '0;
    end
  end

  // stage s2: products with the axes (one multiplier per term)
  logic signed [P_W-1:0] pdx_q [4], pdy_q [4];
  logic signed [Q_W-2:0] m_q [4][8];
  geo_t g2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g2_q <= g1_q;
      for (int k = 0; k < 4; k++) begin
        pdx_q[k] <= P_W'(g1_q.dx) * P_W'(ux1_q[k]);
        pdy_q[k] <= P_W'(g1_q.dy) * P_W'(uy1_q[k]);
        m_q[k][0] <= (Q_W-1)'(ca1_q) * (Q_W-1)'(ux1_q[k]);
        m_q[k][1] <= (Q_W-1)'(sa1_q) * (Q_W-1)'(uy1_q[k]);
        m_q[k][2] <= (Q_W-1)'(sa1_q) * (Q_W-1)'(ux1_q[k]);
        m_q[k][3] <= (Q_W-1)'(ca1_q) * (Q_W-1)'(uy1_q[k]);
        m_q[k][4] <= (Q_W-1)'(cb1_q) * (Q_W-1)'(ux1_q[k]);
        m_q[k][5] <= (Q_W-1)'(sb1_q) * (Q_W-1)'(uy1_q[k]);
        m_q[k][6] <= (Q_W-1)'(sb1_q) * (Q_W-1)'(ux1_q[k]);
        m_q[k][7] <= (Q_W-1)'(cb1_q) * (Q_W-1)'(uy1_q[k]);
      end
    end
  end

  // stage s3: sums and magnitudes
  logic [P_W-1:0] dist3_q [4];
  logic [Q_W-1:0] q3_q [4][4];
  geo_t g3_q;

  function automatic logic [Q_W-1:0] qabs(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    logic signed [P_W-1:0] p;
    if (adv) begin
      g3_q <= g2_q;
      for (int k = 0; k < 4; k++) begin
        p = pdx_q[k] + pdy_q[k];
        dist3_q[k] <= p[P_W-1] ? P_W'(-p) : P_W'(p);
        q3_q[k][0] <= qabs(Q_W'(m_q[k][0]) + Q_W'(m_q[k][1]));
        q3_q[k][1] <= qabs(Q_W'(m_q[k][3]) - Q_W'(m_q[k][2]));
        q3_q[k][2] <= qabs(Q_W'(m_q[k][4]) + Q_W'(m_q[k][5]));
        q3_q[k][3] <= qabs(Q_W'(m_q[k][7]) - Q_W'(m_q[k][6]));
      end
    end
  end

  // stage s4: size times projected direction
  logic [E_W-1:0] e4_q [4][4];
  logic [P_W-1:0] dist4_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        dist4_q[k] <= dist3_q[k];
        e4_q[k][0] <= E_W'(g3_q.aw) * E_W'(q3_q[k][0]);
        e4_q[k][1] <= E_W'(g3_q.ah) * E_W'(q3_q[k][1]);
        e4_q[k][2] <= E_W'(g3_q.bw) * E_W'(q3_q[k][2]);
        e4_q[k][3] <= E_W'(g3_q.bh) * E_W'(q3_q[k][3]);
      end
    end
  end

  // stage s5: compare per axis and combine
  logic [3:0] sep;
  always_comb begin
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] ds;
    for (int k = 0; k < 4; k++) begin
      ext = CMP_W'(e4_q[k][0]) + CMP_W'(e4_q[k][1]) + CMP_W'(e4_q[k][2])
          + CMP_W'(e4_q[k][3]);
      ds  = CMP_W'(dist4_q[k]) << 14;
      sep[k] = ds > ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) colliding_o <= (sep == 4'b0000);
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(colliding_o)))
    else $error("stalled result changed");
  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline advanced during stall");
`endif

endmodule

// ----- tb/sv/oriented_rect_overlap_test_top_tb.sv -----
// oriented_rect_overlap_test_top_tb: self-checking bench for the rotated rectangle overlap test
// predicts each collision flag with its own cordic sine/cosine and separating axis check
// depends on orsat_pkg and oriented_rect_overlap_test_top
`timescale 1ns / 1ps

module oriented_rect_overlap_test_top_tb;
  import orsat_pkg::*;

  localparam int unsigned CWID = 16;
  localparam int unsigned AWID = 16;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [CWID-1:0] left, top;
    logic [CWID-1:0] wd, ht;
    logic [AWID-1:0] ang;
  } rect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CWID-1:0] a_left_i = '0, a_top_i = '0, b_left_i = '0, b_top_i = '0;
  logic [CWID-1:0] a_width_i = '0, a_height_i = '0, b_width_i = '0, b_height_i = '0;
  logic [AWID-1:0] a_angle_i = '0, b_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic colliding_o;

  bit expected_hits[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_random = 1'b1;

  oriented_rect_overlap_test_top #(.COORD_WIDTH(CWID), .ANGLE_WIDTH(AWID)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint arc_step(int i);
    longint steps[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                          20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return steps[i];
  endfunction

  function automatic void sin_cos(input logic [AWID-1:0] ang, output longint c,
                                  output longint s);
    logic [23:0] phase;
    longint x, y, z, xs, ys, rc, rs;
    phase = {ang, 8'b0};
    z = longint'(phase[21:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_step(i);
      end else begin
        x += ys; y -= xs; z += arc_step(i);
      end
    end
    rc = clamp_q14(shr_floor(x + 32768, 16));
    rs = clamp_q14(shr_floor(y + 32768, 16));
    case (phase[23:22])
      2'd0: begin c = rc; s = rs; end
      2'd1: begin c = -rs; s = rc; end
      2'd2: begin c = -rc; s = -rs; end
      default: begin c = rs; s = -rc; end
    endcase
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint half_span(longint w, longint h, longint c, longint s,
                                       longint ux, longint uy);
    return w * absl(c * ux + s * uy) + h * absl(-s * ux + c * uy);
  endfunction

  // true when no edge axis separates the pair; touching counts as overlap
  function automatic bit rects_overlap(rect_t a, rect_t b);
    longint ca, sa, cb, sb, aw, ah, bw, bh, dx, dy, sep_dist, span;
    longint ux[4], uy[4];
    bit hit;
    sin_cos(a.ang, ca, sa);
    sin_cos(b.ang, cb, sb);
    aw = longint'(a.wd); ah = longint'(a.ht);
    bw = longint'(b.wd); bh = longint'(b.ht);
    ux[0] = aw != 0 ? ca : 0;  uy[0] = aw != 0 ? sa : 0;
    ux[1] = ah != 0 ? -sa : 0; uy[1] = ah != 0 ? ca : 0;
    ux[2] = bw != 0 ? cb : 0;  uy[2] = bw != 0 ? sb : 0;
    ux[3] = bh != 0 ? -sb : 0; uy[3] = bh != 0 ? cb : 0;
    // centers kept doubled
    dx = (2 * longint'(b.left) + bw) - (2 * longint'(a.left) + aw);
    dy = (2 * longint'(b.top) + bh) - (2 * longint'(a.top) + ah);
    hit = 1'b1;
    for (int k = 0; k < 4; k++) begin
      sep_dist = absl(dx * ux[k] + dy * uy[k]) << 14;
      span = half_span(aw, ah, ca, sa, ux[k], uy[k]) + half_span(bw, bh, cb, sb, ux[k], uy[k]);
      if (sep_dist > span) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic send_pair(rect_t a, rect_t b);
    a_left_i <= a.left; a_top_i <= a.top; a_width_i <= a.wd;
    a_height_i <= a.ht; a_angle_i <= a.ang;
    b_left_i <= b.left; b_top_i <= b.top; b_width_i <= b.wd;
    b_height_i <= b.ht; b_angle_i <= b.ang;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_hits.push_back(rects_overlap(a, b));
  endtask

  // ends a burst; valid stays high between back-to-back transfers
  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic rect_t rand_rect(bit compact);
    rect_t r;
    if (compact) begin
      r.left = CWID'($urandom_range(0, 2047) - 1024);
      r.top = CWID'($urandom_range(0, 2047) - 1024);
      r.wd = CWID'($urandom_range(0, 1023));
      r.ht = CWID'($urandom_range(0, 1023));
    end else begin
      r.left = CWID'($urandom); r.top = CWID'($urandom);
      r.wd = CWID'($urandom); r.ht = CWID'($urandom);
    end
    r.ang = AWID'($urandom);
    return r;
  endfunction

  function automatic rect_t mk(int l, int t, int w, int h, int ang);
    rect_t r;
    r.left = CWID'(l); r.top = CWID'(t); r.wd = CWID'(w); r.ht = CWID'(h);
    r.ang = AWID'(ang);
    return r;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_pair(mk(0, 0, 16, 16, 0), mk(16, 0, 16, 16, 0));       // touching edges
    send_pair(mk(0, 0, 16, 16, 0), mk(17, 0, 16, 16, 0));       // just apart
    send_pair(mk(0, 0, 160, 16, 16'h2000), mk(0, 0, 16, 160, 16'h6000));
    send_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0));            // both points
    send_pair(mk(0, 0, 0, 64, 16'h1000), mk(100, 0, 0, 64, 0)); // zero width
    send_pair(mk(0, 0, 64, 0, 16'h1000), mk(0, 100, 64, 0, 0)); // zero height
    send_pair(mk(-32768, -32768, 65535, 65535, 16'hffff),
              mk(32767, 32767, 65535, 65535, 16'h8000));
    send_pair(mk(32767, 32767, 0, 0, 16'h4000), mk(-32768, -32768, 0, 0, 16'hc000));
    send_pair(mk(-32768, 32767, 65535, 1, 16'h0001), mk(32767, -32768, 1, 65535, 16'h7fff));
    for (int q = 0; q < 8; q++)
      send_pair(mk(0, 0, 320, 80, q * 16'h2000), mk(300, 40, 80, 320, 16'hffff - q * 16'h2000));
    send_pair(mk(0, 0, 100, 100, 16'h2000), mk(121, 121, 100, 100, 16'h2000));
    send_pair(mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
              mk(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    wait_drained();
  endtask

  task automatic test_random(int count);
    int n;
    n = 0;
    while (n < count) begin
      for (int burst = $urandom_range(1, 40); burst > 0 && n < count; burst--) begin
        // mostly nearby pairs so both outcomes are frequent
        send_pair(rand_rect($urandom_range(0, 9) < 8), rand_rect($urandom_range(0, 9) < 8));
        n++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++) send_pair(rand_rect(1'b1), rand_rect(1'b1));
    wait_drained();
    stall_random = 1'b0;
    for (int i = 0; i < 100; i++) send_pair(rand_rect(1'b1), rand_rect(1'b1));
    wait_drained();
    stall_random = 1'b1;
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      repeat (80) @(posedge clk_i);
      hold_off = 1'b0;
      out_stall_i <= 1'b0;
    end else if (stall_random) begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        $error("colliding: unexpected transfer, actual %0b", colliding_o);
        errors++;
      end else begin
        bit exp_hit;
        exp_hit = expected_hits.pop_front();
        if (colliding_o !== exp_hit) begin
          $error("colliding: expected %0b actual %0b", exp_hit, colliding_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1020);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
